// File: sv/pdc_pkg.sv
package pdc_pkg;

  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned DRIVE_W   = 9;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 8'd50;
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = 8'd5;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 8'd70;
  localparam logic [GAIN_W-1:0] DRIVE_LIMIT_RST = 8'd255;

  localparam logic signed [DRIVE_W-1:0] BUMP_POS_LO = 9'sd6;
  localparam logic signed [DRIVE_W-1:0] BUMP_POS_HI = 9'sd9;
  localparam logic signed [DRIVE_W-1:0] BUMP_POS    = 9'sd10;
  localparam logic signed [DRIVE_W-1:0] BUMP_NEG_LO = -9'sd9;
  localparam logic signed [DRIVE_W-1:0] BUMP_NEG_HI = -9'sd6;
  localparam logic signed [DRIVE_W-1:0] BUMP_NEG    = -9'sd10;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] drive_limit;
  } gains_t;

endpackage

// File: sv/pdc_law.sv
module pdc_law import pdc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned SUM_BITS    = 24
) (
  input  logic        [SAMPLE_BITS-1:0] setpoint_i,
  input  gains_t                        gains_i,
  input  logic        [SAMPLE_BITS-1:0] distance_a_i,
  input  logic        [SAMPLE_BITS-1:0] distance_b_i,
  input  logic signed [SAMPLE_BITS:0]   prev_error_i,
  input  logic signed [SUM_BITS-1:0]    error_sum_i,
  output logic signed [SAMPLE_BITS:0]   error_o,
  output logic signed [SUM_BITS-1:0]    error_sum_o,
  output logic signed [DRIVE_W-1:0]     drive_o,
  output logic                          clamped_o
);

  localparam int unsigned EW  = SAMPLE_BITS + 1;
  localparam int unsigned PW  = EW + GAIN_W + 1;
  localparam int unsigned DW  = EW + GAIN_W + 2;
  localparam int unsigned IW  = SUM_BITS + GAIN_W + 1;
  localparam int unsigned VW  = ((IW > DW) ? IW : DW) + 2;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [EW-1:0]       err_a;
  logic signed [EW-1:0]       err_b;
  logic signed [EW-1:0]       err;
  logic signed [EW:0]         diff;
  logic signed [GAIN_W:0]     gp;
  logic signed [GAIN_W:0]     gi;
  logic signed [GAIN_W:0]     gd;
  logic signed [PW-1:0]       p_term;
  logic signed [IW-1:0]       i_term;
  logic signed [DW-1:0]       d_term;
  logic signed [VW-1:0]       raw;
  logic signed [VW-1:0]       lim;
  logic signed [VW-1:0]       held;
  logic signed [DRIVE_W-1:0]  drv;
  logic signed [SUM_BITS:0]   sum_wide;
  logic                       clip;

  always_comb begin
    err_a  = $signed({1'b0, setpoint_i}) - $signed({1'b0, distance_a_i});
    err_b  = $signed({1'b0, setpoint_i}) - $signed({1'b0, distance_b_i});
    err    = (err_a < err_b) ? err_a : err_b;
    diff   = (EW+1)'(err) - (EW+1)'(prev_error_i);

    gp     = $signed({1'b0, gains_i.gain_p});
    gi     = $signed({1'b0, gains_i.gain_i});
    gd     = $signed({1'b0, gains_i.gain_d});
    p_term = PW'(gp) * PW'(err);
    i_term = IW'(gi) * IW'(error_sum_i);
    d_term = DW'(gd) * DW'(diff);
    raw    = VW'(p_term) + VW'(i_term) + VW'(d_term);

    lim    = VW'($signed({1'b0, gains_i.drive_limit}));
    clip   = 1'b1;
    if (raw > lim) begin
      held = lim;
    end else if (raw < -lim) begin
      held = -lim;
    end else begin
      held = raw;
      clip = 1'b0;
    end

    drv = held[DRIVE_W-1:0];
    if (drv >= BUMP_POS_LO && drv <= BUMP_POS_HI) begin
      drv = BUMP_POS;
    end else if (drv >= BUMP_NEG_LO && drv <= BUMP_NEG_HI) begin
      drv = BUMP_NEG;
    end

    sum_wide = (SUM_BITS+1)'(error_sum_i) + (SUM_BITS+1)'(err);
    if (clip) begin
      error_sum_o = error_sum_i;
    end else if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      error_sum_o = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_o = sum_wide[SUM_BITS-1:0];
    end

    error_o   = err;
    drive_o   = drv;
    clamped_o = clip;
  end

endmodule

// File: sv/pid_distance_controller.sv
// Pipeline: the input register, PID datapath and output register form a
//   two-stage pipeline; a result is loaded into the output register once
//   that register is free to take it, with state updated in one pass.
// Throughput: one request per cycle while the output is not stalled.
// Reset: clears valid flags, previous error and error sum, and loads the
//   default setpoint and gains.
module pid_distance_controller import pdc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned SUM_BITS    = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [SAMPLE_BITS-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic        [SAMPLE_BITS-1:0] distance_a_i,
  input  logic        [SAMPLE_BITS-1:0] distance_b_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DRIVE_W-1:0]    drive_o,
  output logic                         clamped_o
);

  logic                          in_vld_q;
  logic [SAMPLE_BITS-1:0]        dist_a_q;
  logic [SAMPLE_BITS-1:0]        dist_b_q;
  logic                          out_vld_q;
  logic signed [DRIVE_W-1:0]     drive_q;
  logic                          clamped_q;
  logic [SAMPLE_BITS-1:0]        setpoint_q;
  gains_t                        gains_q;
  logic signed [SAMPLE_BITS:0]   prev_error_q;
  logic signed [SAMPLE_BITS:0]   prev_error_d;
  logic signed [SUM_BITS-1:0]    error_sum_q;
  logic signed [SUM_BITS-1:0]    error_sum_d;
  logic signed [DRIVE_W-1:0]     drive_d;
  logic                          clamped_d;
  logic                          advance;
  logic                          in_take;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  pdc_law #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_law (
    .setpoint_i  (setpoint_q),
    .gains_i     (gains_q),
    .distance_a_i(dist_a_q),
    .distance_b_i(dist_b_q),
    .prev_error_i(prev_error_q),
    .error_sum_i (error_sum_q),
    .error_o     (prev_error_d),
    .error_sum_o (error_sum_d),
    .drive_o     (drive_d),
    .clamped_o   (clamped_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q          <= '0;
      gains_q.gain_p      <= GAIN_P_RST;
      gains_q.gain_i      <= GAIN_I_RST;
      gains_q.gain_d      <= GAIN_D_RST;
      gains_q.drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SETPOINT:    setpoint_q          <= cfg_data_i;
        REG_GAIN_P:      gains_q.gain_p      <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:      gains_q.gain_i      <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:      gains_q.gain_d      <= cfg_data_i[GAIN_W-1:0];
        REG_DRIVE_LIMIT: gains_q.drive_limit <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      prev_error_q <= '0;
      error_sum_q  <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q    <= 1'b1;
        prev_error_q <= prev_error_d;
        error_sum_q  <= error_sum_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dist_a_q <= distance_a_i;
      dist_b_q <= distance_b_i;
    end
    if (advance) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && out_vld_q && out_stall_i))
    else $error("result overwritten while stalled");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(error_sum_q) && $stable(prev_error_q)))
    else $error("controller state changed without a request");

  a_no_bump_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !((drive_q >= BUMP_POS_LO && drive_q <= BUMP_POS_HI) ||
                    (drive_q >= BUMP_NEG_LO && drive_q <= BUMP_NEG_HI)))
    else $error("drive left in dead band");

  a_clamp_hold_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && clamped_d) |=> $stable(error_sum_q))
    else $error("error sum moved on a clamped drive");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pdc_pkg::*;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned SUM_BITS    = 24;
  localparam longint SUM_MAX = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam logic [SAMPLE_BITS-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } drive_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [SAMPLE_BITS-1:0]    word_a;
    logic [SAMPLE_BITS-1:0]    word_b;
    bit                        pinned;
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } script_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [SAMPLE_BITS-1:0]       cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [SAMPLE_BITS-1:0]       distance_a_i;
  logic [SAMPLE_BITS-1:0]       distance_b_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [DRIVE_W-1:0]    drive_o;
  logic                         clamped_o;

  pid_distance_controller #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .distance_a_i (distance_a_i),
    .distance_b_i (distance_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o),
    .clamped_o    (clamped_o)
  );

  longint setpoint_reg = 0;
  longint gain_p_reg   = GAIN_P_RST;
  longint gain_i_reg   = GAIN_I_RST;
  longint gain_d_reg   = GAIN_D_RST;
  longint limit_reg    = DRIVE_LIMIT_RST;
  longint prev_err     = 0;
  longint err_sum      = 0;

  drive_t drive_q[$];
  drive_t pin_res;
  bit     pin_on = 1'b0;
  drive_t want_res;
  drive_t new_res;
  int     mismatches = 0;
  int     in_idle_pct = 0;
  int     out_idle_pct = 0;

  script_row_t script [33] = '{
    '{ROW_SAMPLE, REG_SETPOINT,    12'd0,    12'd0,    1'b1, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd4095, 12'd0,    1'b1, -9'sd255, 1'b1},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd0,    12'd0,    1'b1, 9'sd255,  1'b1},
    '{ROW_WRITE,  REG_SETPOINT,    12'd4095, 12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd4095, 12'd4095, 1'b1, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd0,    12'd4095, 1'b1, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_GAIN_P,      12'hF01,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_GAIN_I,      12'd0,    12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_GAIN_D,      12'd0,    12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 12'd100,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd3995, 12'd3995, 1'b1, 9'sd100,  1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd3994, 12'd3994, 1'b1, 9'sd100,  1'b1},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd4088, 12'd4088, 1'b1, 9'sd10,   1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd4090, 12'd4090, 1'b1, 9'sd5,    1'b0},
    '{ROW_WRITE,  REG_SETPOINT,    12'd0,    12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd7,    12'd7,    1'b1, -9'sd10,  1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd6,    12'd6,    1'b1, -9'sd10,  1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd10,   12'd10,   1'b1, -9'sd10,  1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd5,    12'd5,    1'b1, -9'sd5,   1'b0},
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 12'd7,    12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd4095, 12'd4095, 1'b1, -9'sd10,  1'b1},
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 12'd0,    12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd0,    12'd0,    1'b1, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd1,    12'd1,    1'b1, 9'sd0,    1'b1},
    '{ROW_WRITE,  REG_SPARE_LO,    12'hFFF,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_SPARE_HI,    12'hFFF,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd100,  12'd100,  1'b1, 9'sd0,    1'b1},
    '{ROW_WRITE,  REG_GAIN_P,      12'h0FF,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_GAIN_I,      12'hFFF,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_GAIN_D,      12'h0FF,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 12'hFFF,  12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd0,    12'd0,    1'b0, 9'sd0,    1'b0},
    '{ROW_SAMPLE, REG_SETPOINT,    12'd4095, 12'd4095, 1'b1, -9'sd255, 1'b1}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic drive_t pid_update(logic [SAMPLE_BITS-1:0] dist_a,
                                        logic [SAMPLE_BITS-1:0] dist_b);
    longint err_a;
    longint err_b;
    longint err;
    longint raw;
    longint acc;
    drive_t res;
    err_a = setpoint_reg - longint'(dist_a);
    err_b = setpoint_reg - longint'(dist_b);
    err   = (err_a < err_b) ? err_a : err_b;
    raw   = gain_p_reg * err + gain_i_reg * err_sum + gain_d_reg * (err - prev_err);
    res.clamped = 1'b0;
    if (raw > limit_reg) begin
      raw = limit_reg;
      res.clamped = 1'b1;
    end else if (raw < -limit_reg) begin
      raw = -limit_reg;
      res.clamped = 1'b1;
    end else begin
      acc = err_sum + err;
      if (acc > SUM_MAX) acc = SUM_MAX;
      else if (acc < SUM_MIN) acc = SUM_MIN;
      err_sum = acc;
    end
    if (raw >= BUMP_POS_LO && raw <= BUMP_POS_HI) raw = BUMP_POS;
    else if (raw >= BUMP_NEG_LO && raw <= BUMP_NEG_HI) raw = BUMP_NEG;
    prev_err = err;
    res.drive = raw[DRIVE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result: drive %0d clamped %0b", drive_o, clamped_o);
          mismatches++;
        end else begin
          want_res = drive_q.pop_front();
          if (drive_o !== want_res.drive) begin
            $error("drive: expected %0d, got %0d", want_res.drive, drive_o);
            mismatches++;
          end
          if (clamped_o !== want_res.clamped) begin
            $error("clamped: expected %0b, got %0b", want_res.clamped, clamped_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        new_res = pid_update(distance_a_i, distance_b_i);
        if (pin_on) new_res = pin_res;
        drive_q.push_back(new_res);
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  task automatic send_sample(logic [SAMPLE_BITS-1:0] dist_a,
                             logic [SAMPLE_BITS-1:0] dist_b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    distance_a_i <= dist_a;
    distance_b_i <= dist_b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    pin_on = 1'b0;
  endtask

  // hold requests back until the pipeline has drained, then write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_BITS-1:0] data);
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SETPOINT:    setpoint_reg = data;
      REG_GAIN_P:      gain_p_reg = data[GAIN_W-1:0];
      REG_GAIN_I:      gain_i_reg = data[GAIN_W-1:0];
      REG_GAIN_D:      gain_d_reg = data[GAIN_W-1:0];
      REG_DRIVE_LIMIT: limit_reg = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SAMPLE_BITS-1:0] gain_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_BITS'($urandom_range(3));
      default: return SAMPLE_BITS'($urandom_range(DIST_MAX));
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] near_setpoint();
    longint pick;
    pick = setpoint_reg + longint'($urandom_range(48)) - 24;
    if (pick < 0) pick = 0;
    if (pick > longint'(DIST_MAX)) pick = DIST_MAX;
    return pick[SAMPLE_BITS-1:0];
  endfunction

  task automatic pick_settings();
    case ($urandom_range(3))
      0:       cfg_write(REG_SETPOINT, '0);
      1:       cfg_write(REG_SETPOINT, DIST_MAX);
      default: cfg_write(REG_SETPOINT, SAMPLE_BITS'($urandom_range(DIST_MAX)));
    endcase
    cfg_write(REG_GAIN_P, gain_word());
    cfg_write(REG_GAIN_I, gain_word());
    cfg_write(REG_GAIN_D, gain_word());
    case ($urandom_range(5))
      0:       cfg_write(REG_DRIVE_LIMIT, '0);
      1:       cfg_write(REG_DRIVE_LIMIT, 12'h0FF);
      2:       cfg_write(REG_DRIVE_LIMIT, SAMPLE_BITS'($urandom_range(6, 9)));
      default: cfg_write(REG_DRIVE_LIMIT, SAMPLE_BITS'($urandom_range(DIST_MAX)));
    endcase
    if ($urandom_range(3) == 0)
      cfg_write(CFG_IDX_W'(REG_SPARE_LO + $urandom_range(2)),
                SAMPLE_BITS'($urandom_range(DIST_MAX)));
  endtask

  task automatic send_random();
    if ($urandom_range(4) == 0)
      send_sample(SAMPLE_BITS'($urandom_range(DIST_MAX)),
                  SAMPLE_BITS'($urandom_range(DIST_MAX)));
    else
      send_sample(near_setpoint(), near_setpoint());
  endtask

  // walk the error sum far up and back down by the same amount with all
  // gains off, then look at it through the integral gain
  task automatic run_sum_sweep();
    cfg_write(REG_GAIN_P, '0);
    cfg_write(REG_GAIN_I, '0);
    cfg_write(REG_GAIN_D, '0);
    cfg_write(REG_SETPOINT, DIST_MAX);
    repeat (100) send_sample('0, '0);
    cfg_write(REG_SETPOINT, '0);
    repeat (100) begin
      if ($urandom_range(1))
        send_sample(DIST_MAX, SAMPLE_BITS'($urandom_range(DIST_MAX)));
      else
        send_sample(SAMPLE_BITS'($urandom_range(DIST_MAX)), DIST_MAX);
    end
    cfg_write(REG_GAIN_I, 12'd1);
    cfg_write(REG_DRIVE_LIMIT, 12'h0FF);
    send_sample(DIST_MAX, DIST_MAX);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_SETPOINT;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    distance_a_i = '0;
    distance_b_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    in_idle_pct  = 32;
    out_idle_pct = 50;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        cfg_write(script[i].reg_idx, script[i].word_a);
      end else begin
        pin_on = script[i].pinned;
        pin_res.drive = script[i].drive;
        pin_res.clamped = script[i].clamped;
        send_sample(script[i].word_a, script[i].word_b);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 32;
          out_idle_pct = 50;
        end
        1: begin
          in_idle_pct  = 50;
          out_idle_pct = 32;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 6; s++) begin
        pick_settings();
        repeat (55) send_random();
      end
    end

    run_sum_sweep();
    cfg_write(REG_GAIN_P, gain_word());
    cfg_write(REG_GAIN_D, gain_word());
    repeat (30) send_random();

    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/pdc_pkg.sv
sv/pdc_law.sv
sv/pid_distance_controller.sv
sim/tb_top.sv
